### rtl/core/qoi_pse_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pse_pkg
// Shared types, op codes and the colour index hash for the QOI pixel encoder.
// ----------------------------------------------------------------------------
package qoi_pse_pkg;

	localparam int unsigned INDEX_DEPTH = 64;
	localparam int unsigned SLOT_W      = $clog2(INDEX_DEPTH);
	localparam int unsigned PIXEL_W     = 32;
	localparam int unsigned MAX_BYTES   = 6;
	localparam int unsigned OP_BYTES    = 5;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned RUN_W       = 6;

	localparam logic [7:0] OP_RUN  = 8'hC0;
	localparam logic [7:0] OP_DIFF = 8'h40;
	localparam logic [7:0] OP_LUMA = 8'h80;
	localparam logic [7:0] OP_RGB  = 8'hFE;
	localparam logic [7:0] OP_RGBA = 8'hFF;

	localparam logic [RUN_W-1:0]   RUN_MAX  = 6'd62;
	localparam logic [PIXEL_W-1:0] PX_RESET = 32'h0000_00FF;

	// Bytes caused by one pixel, element 0 goes out first.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} op_group_t;

	// State update decided by the encoder.
	typedef struct packed {
		logic             same_px;
		logic             idx_write;
		logic [RUN_W-1:0] run_d;
	} enc_ctl_t;

	// Index slot: (3r + 5g + 7b + 11a) mod 64, only the low six bits matter.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		logic [SLOT_W-1:0] s;
		s = r[SLOT_W-1:0] * 6'd3 + g[SLOT_W-1:0] * 6'd5 + b[SLOT_W-1:0] * 6'd7
			+ a[SLOT_W-1:0] * 6'd11;
		return s;
	endfunction

endpackage

### rtl/core/qoi_pse_ram.sv
// ----------------------------------------------------------------------------
// qoi_pse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qoi_pse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/qoi_pse_encode.sv
// ----------------------------------------------------------------------------
// qoi_pse_encode
// Chooses the QOI op for one pixel and lays out its bytes.
// ----------------------------------------------------------------------------
module qoi_pse_encode (
	input  logic [31:0]                          px,
	input  logic                                 last,
	input  logic [31:0]                          prev,
	input  logic [5:0]                           run,
	input  logic [31:0]                          entry,
	input  logic [qoi_pse_pkg::SLOT_W-1:0]       slot,
	output qoi_pse_pkg::op_group_t               grp,
	output qoi_pse_pkg::enc_ctl_t                ctl
);
	import qoi_pse_pkg::*;

	logic [7:0]        r, g, b, a;
	logic [7:0]        pr, pg, pb, pa;
	logic signed [8:0] dr, dg, db;
	logic signed [9:0] drg, dbg;
	logic              same, hit, flush, diff_ok, luma_ok;
	logic [RUN_W-1:0]  run_next;
	logic [7:0]        run_byte;
	logic [OP_BYTES-1:0][7:0] ops;
	logic [CNT_W-1:0]  op_n;
	logic [1:0]        dr2, dg2, db2;
	logic [3:0]        drg4, dbg4;
	logic [5:0]        dg6;

	assign {r, g, b, a}     = px;
	assign {pr, pg, pb, pa} = prev;

	assign dr  = $signed({1'b0, r}) - $signed({1'b0, pr});
	assign dg  = $signed({1'b0, g}) - $signed({1'b0, pg});
	assign db  = $signed({1'b0, b}) - $signed({1'b0, pb});
	assign drg = $signed({dr[8], dr}) - $signed({dg[8], dg});
	assign dbg = $signed({db[8], db}) - $signed({dg[8], dg});

	assign dr2  = dr[1:0] + 2'd2;
	assign dg2  = dg[1:0] + 2'd2;
	assign db2  = db[1:0] + 2'd2;
	assign dg6  = dg[5:0] + 6'd32;
	assign drg4 = drg[3:0] + 4'd8;
	assign dbg4 = dbg[3:0] + 4'd8;

	assign diff_ok = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1)
		&& (db >= -9'sd2) && (db <= 9'sd1);
	assign luma_ok = (dg >= -9'sd32) && (dg <= 9'sd31) && (drg >= -10'sd8)
		&& (drg <= 10'sd7) && (dbg >= -10'sd8) && (dbg <= 10'sd7);

	assign same     = (px == prev);
	assign hit      = (entry == px);
	assign run_next = run + 6'd1;

	always_comb begin
		ops  = '0;
		op_n = '0;
		if (hit) begin
			ops[0] = {2'b00, slot};
			op_n   = 3'd1;
		end else if (a != pa) begin
			ops  = {a, b, g, r, OP_RGBA};
			op_n = 3'd5;
		end else if (diff_ok) begin
			ops[0] = OP_DIFF | {2'b00, dr2, dg2, db2};
			op_n   = 3'd1;
		end else if (luma_ok) begin
			ops[0] = OP_LUMA | {2'b00, dg6};
			ops[1] = {drg4, dbg4};
			op_n   = 3'd2;
		end else begin
			ops[3:0] = {b, g, r, OP_RGB};
			op_n     = 3'd4;
		end
	end

	always_comb begin
		grp           = '0;
		ctl.same_px   = same;
		ctl.idx_write = 1'b0;
		ctl.run_d     = '0;
		if (same) begin
			// extend the run, flush it when full or at end of image
			flush    = (run_next >= RUN_MAX) || last;
			run_byte = OP_RUN | {2'b00, run};
			grp.bytes[0] = run_byte;
			grp.count    = flush ? 3'd1 : 3'd0;
			ctl.run_d    = flush ? '0 : run_next;
		end else begin
			flush    = (run != '0);
			run_byte = OP_RUN | {2'b00, run - 6'd1};
			if (flush) begin
				grp.bytes = {ops, run_byte};
				grp.count = op_n + 3'd1;
			end else begin
				grp.bytes = {8'h00, ops};
				grp.count = op_n;
			end
			ctl.idx_write = !hit;
		end
	end

endmodule

### rtl/core/qoi_pse_serializer.sv
// ----------------------------------------------------------------------------
// qoi_pse_serializer
// Holds the bytes of one pixel and hands them out one word at a time.
// ----------------------------------------------------------------------------
module qoi_pse_serializer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  qoi_pse_pkg::op_group_t grp,
	output logic                   free,
	output logic                   byte_valid,
	input  logic                   byte_stall,
	output logic [7:0]             op_byte,
	output logic                   last_of_run
);
	import qoi_pse_pkg::*;

	logic [MAX_BYTES-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      pop;

	assign byte_valid  = (cnt_q != '0);
	assign pop         = byte_valid && !byte_stall;
	assign free        = (cnt_q == '0) || ((cnt_q == 3'd1) && pop);
	assign op_byte     = bytes_q[0];
	assign last_of_run = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= grp.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= grp.bytes;
		end else if (pop) begin
			// advance to the next byte
			bytes_q <= {8'h00, bytes_q[MAX_BYTES-1:1]};
		end
	end

endmodule

### rtl/core/qoi_pixel_stream_encoder.sv
// ----------------------------------------------------------------------------
// qoi_pixel_stream_encoder
// QOI op stream encoder: one RGBA8 pixel in, zero to six op bytes out.
// ----------------------------------------------------------------------------
// Timing: a pixel accepted into the stage-1 register is encoded in the following
//   cycle; its bytes load into the serializer when that is free, and go out from there.
// Throughput: one pixel per cycle while each pixel causes at most one byte and the
//   byte side does not stall; longer ops hold pixels back while the single byte port sends them.
// Reset: arst_n clears the previous pixel to 0,0,0,255, the run count and all
//   colour index valid bits at once; no clearing pass, pixels accepted at once.
// ----------------------------------------------------------------------------
module qoi_pixel_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	input  logic       last_pixel,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] op_byte,
	output logic       last_of_run
);
	import qoi_pse_pkg::*;

	// Stage 1: the pixel register; the index RAM read runs alongside it.
	logic                 valid_s1;
	logic [PIXEL_W-1:0]   px_s1;
	logic                 last_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic                 fwd_s1;

	// Image state, updated when the stage-1 pixel advances.
	logic [PIXEL_W-1:0]   prev_q;
	logic [RUN_W-1:0]     run_q;
	logic [INDEX_DEPTH-1:0] vld_q;

	logic                 pixel_accept;
	logic                 s1_adv;
	logic [SLOT_W-1:0]    slot_in;
	logic [PIXEL_W-1:0]   rd_data;
	logic [PIXEL_W-1:0]   entry;
	logic                 idx_we;
	logic                 ser_free;
	op_group_t            grp;
	enc_ctl_t             ctl;

	assign slot_in = slot_of(red, green, blue, alpha);

	// The stage-1 pixel moves on when it has no bytes or the serializer
	// can take its bytes in this cycle.
	assign s1_adv       = valid_s1 && ((grp.count == '0) || ser_free);
	assign pixel_stall  = valid_s1 && !s1_adv;
	assign pixel_accept = pixel_valid && !pixel_stall;

	// The last pixel wipes the index anyway, so it writes nothing.
	assign idx_we = s1_adv && ctl.idx_write && !last_s1;

	// An entry never written since reset or the last image reads as zero.
	// A write to the same slot that landed together with the RAM read missed it, so
	// take it from the previous pixel, which is what was written.
	always_comb begin
		if (fwd_s1) begin
			entry = prev_q;
		end else if (vld_q[slot_s1]) begin
			entry = rd_data;
		end else begin
			entry = '0;
		end
	end

	qoi_pse_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (INDEX_DEPTH)
	) u_index (
		.clk   (clk),
		.we    (idx_we),
		.waddr (slot_s1),
		.wdata (px_s1),
		.re    (pixel_accept),
		.raddr (slot_in),
		.rdata (rd_data)
	);

	qoi_pse_encode u_encode (
		.px    (px_s1),
		.last  (last_s1),
		.prev  (prev_q),
		.run   (run_q),
		.entry (entry),
		.slot  (slot_s1),
		.grp   (grp),
		.ctl   (ctl)
	);

	qoi_pse_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (s1_adv && (grp.count != '0)),
		.grp         (grp),
		.free        (ser_free),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.op_byte     (op_byte),
		.last_of_run (last_of_run)
	);

	// Stage-1 control: valid and the bypass flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (pixel_accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= idx_we && (slot_in == slot_s1);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage-1 payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			px_s1   <= {red, green, blue, alpha};
			last_s1 <= last_pixel;
			slot_s1 <= slot_in;
		end
	end

	// Image state: drop everything back to reset after the last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= PX_RESET;
			run_q  <= '0;
			vld_q  <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				prev_q <= PX_RESET;
				run_q  <= '0;
				vld_q  <= '0;
			end else begin
				run_q <= ctl.run_d;
				if (!ctl.same_px) begin
					prev_q <= px_s1;
				end
				if (idx_we) begin
					vld_q[slot_s1] <= 1'b1;
				end
			end
		end
	end

endmodule

### bench/tb_qoi_pixel_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qoi_pixel_stream_encoder
// Self-checking bench for the QOI pixel stream encoder. A short table of
// directed pixels runs first, then random pixel streams shaped as runs, small
// steps, luma steps, palette revisits and noise, under four flow settings.
// Every op byte is compared with typed-in bytes or with a software encoder
// kept in step with the accepted pixels.
// ----------------------------------------------------------------------------
module tb_qoi_pixel_stream_encoder;

	// Op codes and limits of the encoding, kept apart from the design package.
	localparam logic [7:0] CODE_RUN  = 8'hC0;
	localparam logic [7:0] CODE_DIFF = 8'h40;
	localparam logic [7:0] CODE_LUMA = 8'h80;
	localparam logic [7:0] CODE_RGB  = 8'hFE;
	localparam logic [7:0] CODE_RGBA = 8'hFF;
	localparam int RUN_LIMIT    = 62;
	localparam int PALETTE_SIZE = 64;
	localparam int USE_MODEL    = -1;   // row is checked against the encoder model
	localparam int ITEMS_PER_PHASE = 89;

	// Flow settings for the two channels.
	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_IDLE,
		FLOW_RECEIVER_STALL,
		FLOW_BOTH
	} flow_mode_t;

	// One op byte as it should leave the block.
	typedef struct {
		logic [7:0] value;
		logic       tail;
	} op_word_t;

	// One row of the directed table. fixed_words holds typed-in bytes, the
	// first byte out in the highest used byte lane.
	typedef struct {
		logic [7:0]  r, g, b, a;
		logic        last;
		int          reps;
		int          nfix;
		logic [47:0] fixed_words;
	} pixel_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       pixel_valid;
	logic       pixel_stall;
	logic [7:0] red, green, blue, alpha;
	logic       last_pixel;
	logic       byte_valid;
	logic       byte_stall = 1'b0;
	logic [7:0] op_byte;
	logic       last_of_run;

	flow_mode_t flow_mode = FLOW_FREE;
	int         errors = 0;
	op_word_t   pending_words[$];
	pixel_row_t dir_rows[$];

	// Encoder model state: previous pixel, pending run and colour palette.
	logic [31:0] model_prev;
	int          model_run;
	logic [31:0] model_palette[PALETTE_SIZE];

	// Pixels sent so far, for repeats and palette revisits.
	logic [7:0]  tx_r, tx_g, tx_b, tx_a;
	logic [31:0] sent_hist[8];

	qoi_pixel_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.op_byte    (op_byte),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// Chance in percent that a side idles this cycle under the current flow.
	function automatic int idle_pct(input bit rx_side);
		case (flow_mode)
			FLOW_SENDER_IDLE:    return rx_side ? 0 : 88;
			FLOW_RECEIVER_STALL: return rx_side ? 88 : 0;
			FLOW_BOTH:           return 16;
			default:             return 0;
		endcase
	endfunction

	// Put the encoder model back to its start-of-image state.
	function automatic void clear_model();
		model_prev = 32'h0000_00FF;
		model_run  = 0;
		for (int i = 0; i < PALETTE_SIZE; i++)
			model_palette[i] = '0;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input logic [7:0] r, g, b, a, input logic last,
			input int reps, input int nfix, input logic [47:0] words);
		pixel_row_t row;
		row.r           = r;
		row.g           = g;
		row.b           = b;
		row.a           = a;
		row.last        = last;
		row.reps        = reps;
		row.nfix        = nfix;
		row.fixed_words = words;
		dir_rows = {dir_rows, row};
	endfunction

	// Encode one pixel: return the op bytes it causes and advance the model.
	task automatic encode_pixel(input logic [7:0] r, g, b, a, input logic last,
			output logic [5:0][7:0] ob, output int n);
		logic [31:0] px;
		int slot, dr, dg, db, drg, dbg;
		px = {r, g, b, a};
		ob = '0;
		n  = 0;
		if (px == model_prev) begin
			// Same pixel: extend the run, flush only when full or at image end.
			model_run++;
			if (model_run >= RUN_LIMIT || last) begin
				ob[n] = CODE_RUN | 8'(model_run - 1);
				n++;
				model_run = 0;
			end
		end else begin
			if (model_run > 0) begin
				ob[n] = CODE_RUN | 8'(model_run - 1);
				n++;
				model_run = 0;
			end
			slot = (int'(r) * 3 + int'(g) * 5 + int'(b) * 7 + int'(a) * 11) % PALETTE_SIZE;
			if (model_palette[slot] == px) begin
				ob[n] = 8'(slot);
				n++;
			end else begin
				model_palette[slot] = px;
				if (a == model_prev[7:0]) begin
					// Differences are taken without 8-bit wrap.
					dr  = int'(r) - int'(model_prev[31:24]);
					dg  = int'(g) - int'(model_prev[23:16]);
					db  = int'(b) - int'(model_prev[15:8]);
					drg = dr - dg;
					dbg = db - dg;
					if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
						ob[n] = CODE_DIFF | 8'((dr + 2) << 4) | 8'((dg + 2) << 2) | 8'(db + 2);
						n++;
					end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7
							&& dbg >= -8 && dbg <= 7) begin
						ob[n]     = CODE_LUMA | 8'(dg + 32);
						ob[n + 1] = 8'((drg + 8) << 4) | 8'(dbg + 8);
						n += 2;
					end else begin
						ob[n]     = CODE_RGB;
						ob[n + 1] = r;
						ob[n + 2] = g;
						ob[n + 3] = b;
						n += 4;
					end
				end else begin
					ob[n]     = CODE_RGBA;
					ob[n + 1] = r;
					ob[n + 2] = g;
					ob[n + 3] = b;
					ob[n + 4] = a;
					n += 5;
				end
			end
			model_prev = px;
		end
		if (last)
			clear_model();
	endtask

	// Drive one pixel word, hold it until accepted, then log what it should cause.
	// With nfix >= 0 the typed-in bytes stand in for the model's bytes.
	task automatic send_pixel(input logic [7:0] r, g, b, a, input logic last,
			input int nfix, input logic [47:0] fixed_words);
		logic [5:0][7:0] ob;
		int n;
		op_word_t w;
		if ($urandom_range(0, 99) < idle_pct(1'b0)) begin
			// Idle the pixel side; scramble the payload while valid is low.
			pixel_valid <= 1'b0;
			red         <= 8'($urandom);
			green       <= 8'($urandom);
			blue        <= 8'($urandom);
			alpha       <= 8'($urandom);
			last_pixel  <= 1'($urandom);
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct(1'b0))
				@(posedge clk);
		end
		pixel_valid <= 1'b1;
		red         <= r;
		green       <= g;
		blue        <= b;
		alpha       <= a;
		last_pixel  <= last;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		encode_pixel(r, g, b, a, last, ob, n);
		if (nfix >= 0) begin
			for (int i = 0; i < nfix; i++) begin
				w.value = fixed_words[(nfix - 1 - i) * 8 +: 8];
				w.tail  = (i == nfix - 1);
				pending_words = {pending_words, w};
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				w.value = ob[i];
				w.tail  = (i == n - 1);
				pending_words = {pending_words, w};
			end
		end
		tx_r = r;
		tx_g = g;
		tx_b = b;
		tx_a = a;
		sent_hist[$urandom_range(0, 7)] = {r, g, b, a};
	endtask

	// Random pixel stream. Most pixels relate to the previous one so that runs,
	// DIFF, LUMA and palette hits come up often; the rest is plain noise.
	task automatic random_pixels(input int count);
		logic [7:0] nr, ng, nb, na;
		logic [31:0] pick;
		int sel, reps, dg, left;
		left = count;
		while (left > 0) begin
			sel  = $urandom_range(0, 99);
			reps = 1;
			nr = tx_r;
			ng = tx_g;
			nb = tx_b;
			na = tx_a;
			if (sel < 22) begin
				// Repeat: mostly short runs, now and then long enough to fill one.
				reps = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 6);
			end else if (sel < 42) begin
				nr = tx_r + 8'($urandom_range(0, 3)) - 8'd2;
				ng = tx_g + 8'($urandom_range(0, 3)) - 8'd2;
				nb = tx_b + 8'($urandom_range(0, 3)) - 8'd2;
			end else if (sel < 62) begin
				dg = $urandom_range(0, 63) - 32;
				ng = tx_g + 8'(dg);
				nr = tx_r + 8'(dg + $urandom_range(0, 15) - 8);
				nb = tx_b + 8'(dg + $urandom_range(0, 15) - 8);
			end else if (sel < 77) begin
				pick = sent_hist[$urandom_range(0, 7)];
				{nr, ng, nb, na} = pick;
			end else if (sel < 90) begin
				nr = 8'($urandom);
				ng = 8'($urandom);
				nb = 8'($urandom);
			end else begin
				{nr, ng, nb, na} = $urandom;
			end
			for (int i = 0; i < reps; i++)
				send_pixel(nr, ng, nb, na,
					(i == reps - 1) && ($urandom_range(0, 39) == 0), USE_MODEL, '0);
			left -= reps;
		end
	endtask

	// Byte side: check every accepted word against the oldest expectation,
	// then pick the stall for the next cycle.
	always @(posedge clk) begin
		op_word_t want;
		if (byte_valid && !byte_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, got op_byte=%h last_of_run=%b",
					$time, op_byte, last_of_run);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (op_byte !== want.value) begin
					$display("%0t: op_byte expected %h, got %h", $time, want.value, op_byte);
					errors++;
				end
				if (last_of_run !== want.tail) begin
					$display("%0t: last_of_run expected %b, got %b", $time, want.tail,
						last_of_run);
					errors++;
				end
			end
		end
		byte_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		alpha       = '0;
		last_pixel  = 1'b0;
		tx_r = 8'd0;
		tx_g = 8'd0;
		tx_b = 8'd0;
		tx_a = 8'd255;
		for (int i = 0; i < 8; i++)
			sent_hist[i] = 32'h0000_00FF;
		clear_model();

		// Directed table: r, g, b, a, last, repeats, typed byte count, typed bytes.
		// Zero pixel hits the cleared palette entry 0, then repeats.
		add_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1, 1, 48'h00);
		add_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1, 0, 48'h0);
		// Last pixel flushes the run of two; state goes back to start.
		add_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1, 1, 48'hC1);
		// Pixel equal to the start pixel as the last one: run of one.
		add_row(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1, 1, 48'hC0);
		// Channel jumps of 255 do not wrap into DIFF.
		add_row(8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 1, 4, 48'hFE_FF_00_00);
		add_row(8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1, 4, 48'hFE_00_00_00);
		add_row(8'd1, 8'd1, 8'd1, 8'd255, 1'b0, 1, 1, 48'h7F);
		add_row(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1, 4, 48'hFE_FF_FF_FF);
		add_row(8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1, 5, 48'hFF_FF_FF_FF_00);
		// Back to white: palette hit on slot 38.
		add_row(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1, 1, 48'h26);
		// DIFF at both ends of its range.
		add_row(8'd253, 8'd253, 8'd253, 8'd255, 1'b0, 1, 1, 48'h40);
		add_row(8'd254, 8'd254, 8'd254, 8'd255, 1'b0, 1, USE_MODEL, 48'h0);
		// LUMA at both ends, then one step past it.
		add_row(8'd214, 8'd222, 8'd214, 8'd255, 1'b0, 1, USE_MODEL, 48'h0);
		add_row(8'd252, 8'd253, 8'd252, 8'd255, 1'b0, 1, USE_MODEL, 48'h0);
		add_row(8'd219, 8'd220, 8'd219, 8'd255, 1'b0, 1, USE_MODEL, 48'h0);
		// Run broken by an alpha change: run flush plus a full RGBA op.
		add_row(8'd219, 8'd220, 8'd219, 8'd255, 1'b0, 3, USE_MODEL, 48'h0);
		add_row(8'd10, 8'd20, 8'd30, 8'd40, 1'b0, 1, USE_MODEL, 48'h0);
		add_row(8'd10, 8'd20, 8'd30, 8'd40, 1'b0, 2, USE_MODEL, 48'h0);
		// Last pixel that breaks a run.
		add_row(8'd219, 8'd220, 8'd219, 8'd255, 1'b1, 1, USE_MODEL, 48'h0);
		// Fresh image: palette cleared again.
		add_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1, 1, 48'h00);
		add_row(8'd5, 8'd5, 8'd5, 8'd5, 1'b0, 1, 5, 48'hFF_05_05_05_05);
		add_row(8'd5, 8'd5, 8'd5, 8'd5, 1'b1, 1, 1, 48'hC0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with both sides flowing freely.
		foreach (dir_rows[k]) begin
			for (int i = 0; i < dir_rows[k].reps; i++)
				send_pixel(dir_rows[k].r, dir_rows[k].g, dir_rows[k].b, dir_rows[k].a,
					dir_rows[k].last && (i == dir_rows[k].reps - 1),
					dir_rows[k].nfix, dir_rows[k].fixed_words);
		end

		// Random streams under each flow setting.
		flow_mode = FLOW_FREE;
		random_pixels(ITEMS_PER_PHASE);
		flow_mode = FLOW_SENDER_IDLE;
		random_pixels(ITEMS_PER_PHASE);
		flow_mode = FLOW_RECEIVER_STALL;
		random_pixels(ITEMS_PER_PHASE);
		flow_mode = FLOW_BOTH;
		random_pixels(ITEMS_PER_PHASE);

		// Drop valid and drain the byte side, then allow for pipeline latency.
		pixel_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
